// File: hdl/dsdw_pkg.sv
// Shared constants and types for the signed decimal digit display writer.
`timescale 1ns / 1ps

package dsdw_pkg;

  localparam int NUMBER_BITS   = 32;
  localparam int RADIX         = 10;
  // Enough decimal digits for the full unsigned magnitude range.
  localparam int BCD_DIGITS    = (NUMBER_BITS * 30103) / 100000 + 1;
  localparam int BCD_BITS      = 4 * BCD_DIGITS;
  localparam int CNT_W         = $clog2(NUMBER_BITS);
  localparam int ADDR_W        = 4;
  localparam int CODE_W        = 4;
  localparam int OUT_BITS      = ADDR_W + CODE_W;

  localparam logic [CODE_W-1:0] CODE_BLANK  = 4'hF;
  localparam logic [CODE_W-1:0] CODE_MINUS  = 4'hA;
  localparam logic [ADDR_W-1:0] FIRST_ADDR  = 4'h1;
  localparam logic [ADDR_W-1:0] MAX_POS     = 4'h8;

  // Shift-and-add-3 correction: a digit at or above half the radix is
  // corrected before the next doubling.
  localparam logic [3:0] DABBLE_MIN = 4'(RADIX / 2);
  localparam logic [3:0] DABBLE_ADD = 4'((16 - RADIX) / 2);

  typedef struct packed {
    logic              negative;
    logic [ADDR_W-1:0] blanks;
  } emit_cmd_t;

  typedef struct packed {
    logic                busy;
    logic [BCD_BITS-1:0] bcd;
  } conv_status_t;

endpackage

// File: hdl/signed_decimal_digit_display_writer.sv
// Top level: takes a signed number, emits display register writes for it.
// The first write beat is a blank, registered from the blanking state entered on acceptance.
// Numbers are not overlapped: digits wait for the bit-serial converter to finish,
// and every blank, digit and sign beat waits for a free output slot.
// The next number is accepted once the previous run's last beat is registered.
// Reset: digit_count returns to 8, sequencer and converter go idle.
`timescale 1ns / 1ps

module signed_decimal_digit_display_writer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [dsdw_pkg::NUMBER_BITS-1:0]    s_tdata,   // number[31:0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [dsdw_pkg::OUT_BITS-1:0]       m_tdata,   // reg_address[3:0], digit_code[7:4]
  output logic                                m_tlast,   // last
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dsdw_pkg::ADDR_W-1:0]         cfg_data   // digit_count[3:0]
);
  import dsdw_pkg::*;

  logic [ADDR_W-1:0]      digit_count;
  logic                   accept;
  logic                   emit_idle;
  logic [NUMBER_BITS-1:0] mag;
  emit_cmd_t              cmd;
  conv_status_t           conv;

  assign cfg_ready = 1'b1;
  assign s_tready  = emit_idle;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= MAX_POS;
    end else if (cfg_valid && cfg_ready) begin
      digit_count <= cfg_data;
    end
  end

  // Two's complement magnitude; the most negative value maps to its unsigned size.
  assign mag = s_tdata[NUMBER_BITS-1] ? (~s_tdata + 1'b1) : s_tdata;

  always_comb begin
    cmd.negative = s_tdata[NUMBER_BITS-1];
    if (digit_count == '0) begin
      cmd.blanks = FIRST_ADDR;
    end else if (digit_count > MAX_POS) begin
      cmd.blanks = MAX_POS;
    end else begin
      cmd.blanks = digit_count;
    end
  end

  dsdw_dabble u_dabble (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .mag    (mag),
    .status (conv)
  );

  dsdw_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .cmd      (cmd),
    .conv     (conv),
    .idle     (emit_idle),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  a_accept_conv_idle: assert property (@(posedge clk) disable iff (rst)
      accept |-> !conv.busy)
    else $error("number accepted while converter busy");

endmodule

// File: hdl/dsdw_dabble.sv
// Bit-serial binary to BCD converter (one magnitude bit per cycle).
`timescale 1ns / 1ps

module dsdw_dabble (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [dsdw_pkg::NUMBER_BITS-1:0] mag,
  output dsdw_pkg::conv_status_t          status
);
  import dsdw_pkg::*;

  logic                   busy;
  logic [CNT_W-1:0]       cnt;
  logic [NUMBER_BITS-1:0] bin;
  logic [BCD_BITS-1:0]    bcd;
  logic [BCD_BITS-1:0]    adj;
  logic [BCD_BITS-1:0]    bcd_next;

  // Correct each digit independently, then shift in the next magnitude bit.
  always_comb begin
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if (bcd[4*d +: 4] >= DABBLE_MIN) begin
        adj[4*d +: 4] = bcd[4*d +: 4] + DABBLE_ADD;
      end else begin
        adj[4*d +: 4] = bcd[4*d +: 4];
      end
    end
    bcd_next = {adj[BCD_BITS-2:0], bin[NUMBER_BITS-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUMBER_BITS - 1);
      bin  <= mag;
      bcd  <= '0;
    end else if (busy) begin
      bcd <= bcd_next;
      bin <= {bin[NUMBER_BITS-2:0], 1'b0};
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign status.busy = busy;
  assign status.bcd  = bcd;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("conversion started while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("conversion did not start");

endmodule

// File: hdl/dsdw_emit.sv
// Display write sequencer: blanks, digits least significant first, then sign if negative.
`timescale 1ns / 1ps

module dsdw_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  dsdw_pkg::emit_cmd_t           cmd,
  input  dsdw_pkg::conv_status_t        conv,
  output logic                          idle,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [dsdw_pkg::OUT_BITS-1:0] m_tdata,  // reg_address[3:0], digit_code[7:4]
  output logic                          m_tlast   // last
);
  import dsdw_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_BLANK, S_WAIT, S_DIGIT, S_SIGN} state_t;

  state_t              state;
  logic                neg;
  logic [ADDR_W-1:0]   cnt;
  logic [BCD_BITS-1:0] digits;
  logic [BCD_BITS-1:0] rest;
  logic                slot;
  logic                rest_zero;
  logic                beat_load;

  assign slot      = !m_tvalid || m_tready;
  assign rest      = digits >> 4;
  assign rest_zero = (rest == '0);
  assign idle      = (state == S_IDLE);
  assign beat_load = slot && (state == S_BLANK || state == S_DIGIT || state == S_SIGN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // Drop valid once the beat is taken, unless a new beat is loaded.
      if (m_tvalid && m_tready && !beat_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            neg   <= cmd.negative;
            cnt   <= cmd.blanks;
            state <= S_BLANK;
          end
        end
        S_BLANK: begin
          if (slot) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {CODE_BLANK, cnt};
            m_tlast  <= 1'b0;
            if (cnt == FIRST_ADDR) begin
              cnt   <= FIRST_ADDR;
              state <= S_WAIT;
            end else begin
              cnt <= cnt - 1'b1;
            end
          end
        end
        S_WAIT: begin
          // Hold until the converter has finished the magnitude.
          if (!conv.busy) begin
            digits <= conv.bcd;
            state  <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (slot) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {digits[CODE_W-1:0], cnt};
            m_tlast  <= rest_zero && !neg;
            digits   <= rest;
            cnt      <= cnt + 1'b1;
            if (rest_zero) begin
              state <= neg ? S_SIGN : S_IDLE;
            end
          end
        end
        S_SIGN: begin
          if (slot) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {CODE_MINUS, cnt};
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_minus_last: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && (m_tdata[OUT_BITS-1:ADDR_W] == CODE_MINUS) |-> m_tlast)
    else $error("minus code not on final beat");
  a_addr_nonzero: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> (m_tdata[ADDR_W-1:0] != '0))
    else $error("beat with address zero");

endmodule
